// ----- hw/rtl/ddrf_pkg.sv -----
// ddrf_pkg: shared widths, mode codes, register indexes and reset values
// for the destination rectangle fit block
// no dependencies
package ddrf_pkg;

  // fixed field widths
  localparam int MODE_W    = 2;
  localparam int RATIO_W   = 24;
  localparam int FACTOR_W  = 5;
  localparam int OUT_W     = 16;
  localparam int CFG_IDX_W = 3;
  localparam int OUT_MAX   = 65535;

  // fit mode codes
  localparam logic [MODE_W-1:0] MODE_INTEGER = 2'd0;
  localparam logic [MODE_W-1:0] MODE_STRETCH = 2'd1;
  localparam logic [MODE_W-1:0] MODE_FIT     = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FIT_MODE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ASPECT     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SRC_WIDTH  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SRC_HEIGHT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_INT_FACTOR = 3'd4;

  // register reset values
  localparam logic [MODE_W-1:0]   RST_FIT_MODE   = MODE_STRETCH;
  localparam logic [RATIO_W-1:0]  RST_ASPECT     = 24'd87381;
  localparam int                  RST_SRC_WIDTH  = 320;
  localparam int                  RST_SRC_HEIGHT = 240;
  localparam logic [FACTOR_W-1:0] RST_INT_FACTOR = 5'd1;

endpackage

// ----- hw/rtl/ddrf_front.sv -----
// ddrf_front: first pipeline stage, aspect multiply, integer scale products
// and divider setup for the height-from-width quotient
// depends on ddrf_pkg
module ddrf_front
  import ddrf_pkg::*;
#(
  parameter int DIM_BITS  = 12,
  parameter int FRAC_BITS = 16
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    load,
  input  logic                                    in_valid,
  input  logic [DIM_BITS-1:0]                     dw,
  input  logic [DIM_BITS-1:0]                     dh,
  input  logic [RATIO_W-1:0]                      aspect,
  input  logic [DIM_BITS-1:0]                     src_w,
  input  logic [DIM_BITS-1:0]                     src_h,
  input  logic [FACTOR_W-1:0]                     factor,
  output logic                                    out_valid,
  output logic [RATIO_W:0]                        rem,
  output logic [DIM_BITS-1:0]                     quo,
  output logic [DIM_BITS-1:0]                     o_dw,
  output logic [DIM_BITS-1:0]                     o_dh,
  output logic [DIM_BITS+RATIO_W-FRAC_BITS-1:0]   fitw,
  output logic [DIM_BITS+FACTOR_W-1:0]            iw,
  output logic [DIM_BITS+FACTOR_W-1:0]            ih
);

  localparam int PROD_W = DIM_BITS + RATIO_W;
  localparam int NUM_W  = DIM_BITS + FRAC_BITS;
  localparam int REM_W  = RATIO_W + 1;
  localparam int ISZ_W  = DIM_BITS + FACTOR_W;

  logic [PROD_W-1:0] prod;
  logic [NUM_W-1:0]  num;

  // width from height, dh * aspect
  assign prod = PROD_W'(dh) * PROD_W'(aspect);

  // dividend dw << FRAC_BITS, top part seeds the remainder
  assign num = {dw, {FRAC_BITS{1'b0}}};

  // stage valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= in_valid;
    end
  end

  // stage payload
  always_ff @(posedge clk) begin
    if (load) begin
      rem  <= REM_W'(num[NUM_W-1:DIM_BITS]);
      quo  <= num[DIM_BITS-1:0];
      o_dw <= dw;
      o_dh <= dh;
      fitw <= prod[PROD_W-1:FRAC_BITS];
      iw   <= ISZ_W'(src_w) * ISZ_W'(factor);
      ih   <= ISZ_W'(src_h) * ISZ_W'(factor);
    end
  end

endmodule

// ----- hw/rtl/ddrf_div_stage.sv -----
// ddrf_div_stage: one restoring division step, one quotient bit per stage,
// carries the side payload along unchanged
// depends on ddrf_pkg
module ddrf_div_stage
  import ddrf_pkg::*;
#(
  parameter int DIM_BITS = 12,
  parameter int SIDE_W   = 8
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                load,
  input  logic                in_valid,
  input  logic [RATIO_W-1:0]  aspect,
  input  logic [RATIO_W:0]    rem_in,
  input  logic [DIM_BITS-1:0] quo_in,
  input  logic [SIDE_W-1:0]   side_in,
  output logic                out_valid,
  output logic [RATIO_W:0]    rem_out,
  output logic [DIM_BITS-1:0] quo_out,
  output logic [SIDE_W-1:0]   side_out
);

  logic [RATIO_W:0] trial;
  logic [RATIO_W:0] diff;
  logic             ge;

  // shift in next dividend bit, compare and subtract
  assign trial = {rem_in[RATIO_W-1:0], quo_in[DIM_BITS-1]};
  assign diff  = trial - {1'b0, aspect};
  assign ge    = trial >= {1'b0, aspect};

  // stage valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= in_valid;
    end
  end

  // stage payload, quotient bit enters at the bottom
  always_ff @(posedge clk) begin
    if (load) begin
      rem_out  <= ge ? diff : trial;
      quo_out  <= {quo_in[DIM_BITS-2:0], ge};
      side_out <= side_in;
    end
  end

endmodule

// ----- hw/rtl/ddrf_select.sv -----
// ddrf_select: picks destination width and height for the current mode,
// with integer saturation and the fit-mode overflow test
// depends on ddrf_pkg
module ddrf_select
  import ddrf_pkg::*;
#(
  parameter int DIM_BITS  = 12,
  parameter int FRAC_BITS = 16
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    load,
  input  logic                                    in_valid,
  input  logic [MODE_W-1:0]                       mode,
  input  logic [DIM_BITS-1:0]                     dw,
  input  logic [DIM_BITS-1:0]                     dh,
  input  logic [DIM_BITS+RATIO_W-FRAC_BITS-1:0]   fitw,
  input  logic [DIM_BITS+FACTOR_W-1:0]            iw,
  input  logic [DIM_BITS+FACTOR_W-1:0]            ih,
  input  logic [DIM_BITS-1:0]                     quo,
  output logic                                    out_valid,
  output logic [DIM_BITS-1:0]                     o_dw,
  output logic [DIM_BITS-1:0]                     o_dh,
  output logic [OUT_W-1:0]                        w,
  output logic [OUT_W-1:0]                        h
);

  localparam int FITW_W = DIM_BITS + RATIO_W - FRAC_BITS;

  logic             wide;
  logic [OUT_W-1:0] iw_sat;
  logic [OUT_W-1:0] ih_sat;
  logic [OUT_W-1:0] w_next;
  logic [OUT_W-1:0] h_next;

  // fitted width wider than the display
  assign wide = fitw > FITW_W'(dw);

  // integer sizes saturate at the output range
  assign iw_sat = (32'(iw) > 32'(OUT_MAX)) ? OUT_W'(OUT_MAX) : OUT_W'(iw);
  assign ih_sat = (32'(ih) > 32'(OUT_MAX)) ? OUT_W'(OUT_MAX) : OUT_W'(ih);

  // mode select, unused mode code acts as stretch
  always_comb begin
    case (mode)
      MODE_INTEGER: begin
        w_next = iw_sat;
        h_next = ih_sat;
      end
      MODE_FIT: begin
        if (wide) begin
          w_next = OUT_W'(dw);
          h_next = OUT_W'(quo);
        end else begin
          w_next = OUT_W'(fitw);
          h_next = OUT_W'(dh);
        end
      end
      default: begin
        w_next = OUT_W'(dw);
        h_next = OUT_W'(dh);
      end
    endcase
  end

  // stage valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= in_valid;
    end
  end

  // stage payload
  always_ff @(posedge clk) begin
    if (load) begin
      o_dw <= dw;
      o_dh <= dh;
      w    <= w_next;
      h    <= h_next;
    end
  end

endmodule

// ----- hw/rtl/ddrf_center.sv -----
// ddrf_center: centering offsets, halved toward zero, and the output register
// depends on ddrf_pkg
module ddrf_center
  import ddrf_pkg::*;
#(
  parameter int DIM_BITS = 12
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 load,
  input  logic                 in_valid,
  input  logic [DIM_BITS-1:0]  dw,
  input  logic [DIM_BITS-1:0]  dh,
  input  logic [OUT_W-1:0]     w,
  input  logic [OUT_W-1:0]     h,
  output logic                 out_valid,
  output logic [4*OUT_W-1:0]   tdata
);

  localparam int DIFF_W = OUT_W + 2;

  logic signed [DIFF_W-1:0] dx;
  logic signed [DIFF_W-1:0] dy;
  logic signed [DIFF_W-1:0] hx;
  logic signed [DIFF_W-1:0] hy;
  logic signed [DIFF_W-1:0] x;
  logic signed [DIFF_W-1:0] y;

  // free space on each axis, negative when the image overflows
  assign dx = $signed(DIFF_W'(dw)) - $signed(DIFF_W'(w));
  assign dy = $signed(DIFF_W'(dh)) - $signed(DIFF_W'(h));

  // halve toward zero: bias negatives by one before the arithmetic shift
  assign hx = dx + $signed(DIFF_W'(dx[DIFF_W-1]));
  assign hy = dy + $signed(DIFF_W'(dy[DIFF_W-1]));
  assign x  = hx >>> 1;
  assign y  = hy >>> 1;

  // output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= in_valid;
    end
  end

  // output beat
  always_ff @(posedge clk) begin
    if (load) begin
      tdata <= {h, w, y[OUT_W-1:0], x[OUT_W-1:0]};
    end
  end

endmodule

// ----- hw/rtl/display_dest_rect_fit.sv -----
// Destination rectangle fit: one display size in, one rectangle (x, y, width,
// height) out, in integer, stretch or keep-aspect mode. The block is a
// pipeline of DIM_BITS+3 stages (15 at the default): one multiply stage, one
// restoring divider stage per quotient bit for the height-from-width quotient,
// a mode select stage and a centering stage that is also the output register.
// It takes one beat per clock while the output is not held; a stage holds its
// beat only while it and every stage ahead are full and m_tready is low, so
// bubbles close up under backpressure. The user must see that configuration is
// written only while no beat is in flight; the block does not enforce it.
// depends on ddrf_pkg, ddrf_front, ddrf_div_stage, ddrf_select, ddrf_center
module display_dest_rect_fit
  import ddrf_pkg::*;
#(
  parameter int DIM_BITS  = 12,
  parameter int FRAC_BITS = 16
) (
  input  logic                                   clk,
  input  logic                                   rst,
  // input beat
  input  logic                                   s_tvalid,
  output logic                                   s_tready,
  // device_width, device_height, zero fill to bytes
  input  logic [((2*DIM_BITS+7)/8)*8-1:0]        s_tdata,
  // result beat
  output logic                                   m_tvalid,
  input  logic                                   m_tready,
  // rect_x, rect_y, rect_width, rect_height
  output logic [4*OUT_W-1:0]                     m_tdata,
  // configuration writes
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]                   cfg_index,
  input  logic [RATIO_W-1:0]                     cfg_data
);

  localparam int NST    = DIM_BITS + 3;
  localparam int REM_W  = RATIO_W + 1;
  localparam int FITW_W = DIM_BITS + RATIO_W - FRAC_BITS;
  localparam int ISZ_W  = DIM_BITS + FACTOR_W;
  localparam int SIDE_W = 2*DIM_BITS + FITW_W + 2*ISZ_W;
  localparam int SEL_ST = DIM_BITS + 1;

  // configuration registers
  logic [MODE_W-1:0]   fit_mode;
  logic [RATIO_W-1:0]  aspect_ratio;
  logic [DIM_BITS-1:0] source_width;
  logic [DIM_BITS-1:0] source_height;
  logic [FACTOR_W-1:0] integer_factor;

  // pipeline control
  logic [NST-1:0] vld;
  logic [NST-1:0] ld;

  // front stage outputs
  logic [DIM_BITS-1:0] f_dw;
  logic [DIM_BITS-1:0] f_dh;
  logic [FITW_W-1:0]   f_fitw;
  logic [ISZ_W-1:0]    f_iw;
  logic [ISZ_W-1:0]    f_ih;

  // divider chain
  logic [REM_W-1:0]    rem_s  [DIM_BITS+1];
  logic [DIM_BITS-1:0] quo_s  [DIM_BITS+1];
  logic [SIDE_W-1:0]   side_s [DIM_BITS+1];

  // divider tail unpacked
  logic [DIM_BITS-1:0] d_dw;
  logic [DIM_BITS-1:0] d_dh;
  logic [FITW_W-1:0]   d_fitw;
  logic [ISZ_W-1:0]    d_iw;
  logic [ISZ_W-1:0]    d_ih;

  // select stage outputs
  logic [DIM_BITS-1:0] s_dw;
  logic [DIM_BITS-1:0] s_dh;
  logic [OUT_W-1:0]    s_w;
  logic [OUT_W-1:0]    s_h;

  // configuration port
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      fit_mode       <= RST_FIT_MODE;
      aspect_ratio   <= RST_ASPECT;
      source_width   <= DIM_BITS'(RST_SRC_WIDTH);
      source_height  <= DIM_BITS'(RST_SRC_HEIGHT);
      integer_factor <= RST_INT_FACTOR;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_FIT_MODE:   fit_mode       <= cfg_data[MODE_W-1:0];
        REG_ASPECT:     aspect_ratio   <= cfg_data;
        REG_SRC_WIDTH:  source_width   <= cfg_data[DIM_BITS-1:0];
        REG_SRC_HEIGHT: source_height  <= cfg_data[DIM_BITS-1:0];
        REG_INT_FACTOR: integer_factor <= cfg_data[FACTOR_W-1:0];
        default: ;
      endcase
    end
  end

  // a stage loads when it or any stage ahead of it has room, or when m_tready is high
  for (genvar i = 0; i < NST; i++) begin : g_load
    assign ld[i] = ~(&vld[NST-1:i]) | m_tready;
  end

  assign s_tready = ld[0];
  assign m_tvalid = vld[NST-1];

  // multiply stage
  ddrf_front #(
    .DIM_BITS  (DIM_BITS),
    .FRAC_BITS (FRAC_BITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .load      (ld[0]),
    .in_valid  (s_tvalid),
    .dw        (s_tdata[DIM_BITS-1:0]),
    .dh        (s_tdata[2*DIM_BITS-1:DIM_BITS]),
    .aspect    (aspect_ratio),
    .src_w     (source_width),
    .src_h     (source_height),
    .factor    (integer_factor),
    .out_valid (vld[0]),
    .rem       (rem_s[0]),
    .quo       (quo_s[0]),
    .o_dw      (f_dw),
    .o_dh      (f_dh),
    .fitw      (f_fitw),
    .iw        (f_iw),
    .ih        (f_ih)
  );

  assign side_s[0] = {f_ih, f_iw, f_fitw, f_dh, f_dw};

  // divider stages, one quotient bit each
  for (genvar k = 0; k < DIM_BITS; k++) begin : g_div
    ddrf_div_stage #(
      .DIM_BITS (DIM_BITS),
      .SIDE_W   (SIDE_W)
    ) u_div (
      .clk       (clk),
      .rst       (rst),
      .load      (ld[k+1]),
      .in_valid  (vld[k]),
      .aspect    (aspect_ratio),
      .rem_in    (rem_s[k]),
      .quo_in    (quo_s[k]),
      .side_in   (side_s[k]),
      .out_valid (vld[k+1]),
      .rem_out   (rem_s[k+1]),
      .quo_out   (quo_s[k+1]),
      .side_out  (side_s[k+1])
    );
  end

  assign {d_ih, d_iw, d_fitw, d_dh, d_dw} = side_s[DIM_BITS];

  // mode select stage
  ddrf_select #(
    .DIM_BITS  (DIM_BITS),
    .FRAC_BITS (FRAC_BITS)
  ) u_select (
    .clk       (clk),
    .rst       (rst),
    .load      (ld[SEL_ST]),
    .in_valid  (vld[SEL_ST-1]),
    .mode      (fit_mode),
    .dw        (d_dw),
    .dh        (d_dh),
    .fitw      (d_fitw),
    .iw        (d_iw),
    .ih        (d_ih),
    .quo       (quo_s[DIM_BITS]),
    .out_valid (vld[SEL_ST]),
    .o_dw      (s_dw),
    .o_dh      (s_dh),
    .w         (s_w),
    .h         (s_h)
  );

  // centering stage and output register
  ddrf_center #(
    .DIM_BITS (DIM_BITS)
  ) u_center (
    .clk       (clk),
    .rst       (rst),
    .load      (ld[NST-1]),
    .in_valid  (vld[SEL_ST]),
    .dw        (s_dw),
    .dh        (s_dh),
    .w         (s_w),
    .h         (s_h),
    .out_valid (vld[NST-1]),
    .tdata     (m_tdata)
  );

`ifndef SYNTHESIS
  // an accepted beat lands in the front stage
  a_accept_fills_front: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> vld[0])
    else $error("accepted beat missing from front stage");

  // input stalls only when every stage is full and the output is held
  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> (&vld) && !m_tready)
    else $error("input stalled with room in the pipeline");

  // an empty output register never blocks the input
  a_empty_out_takes: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input stalled with empty output register");
`endif

endmodule
